>>> rtl/sli_pkg.sv
// ----------------------------------------------------------------------------
// Sorted list insert package
// Shared constants, request and response types and the link between cells.
// ----------------------------------------------------------------------------
package sli_pkg;

   localparam int DEPTH       = 32;
   localparam int VALUE_WIDTH = 32;

   localparam int IDX_WIDTH   = $clog2(DEPTH);
   localparam int CNT_WIDTH   = $clog2(DEPTH + 1);

   // Fixed field widths of the request and response.
   localparam int DATA_WIDTH  = 32;
   localparam int POS_WIDTH   = 6;
   localparam int COUNT_WIDTH = 7;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_DRAIN  = 1'b1;

   localparam logic [1:0] STATUS_INSERTED      = 2'd0;
   localparam logic [1:0] STATUS_DROPPED       = 2'd1;
   localparam logic [1:0] STATUS_DRAINED       = 2'd2;
   localparam logic [1:0] STATUS_DRAINED_EMPTY = 2'd3;

   typedef struct packed {
      logic                          kind;
      logic signed [DATA_WIDTH-1:0]  value;
   } sli_req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0]  result_value;
      logic [POS_WIDTH-1:0]          position;
      logic [COUNT_WIDTH-1:0]        entry_count;
      logic [1:0]                    status;
      logic                          last;
   } sli_rsp_type;

   // Command broadcast to every cell in the row.
   typedef struct packed {
      logic                          insert;
      logic                          drain;
      logic signed [VALUE_WIDTH-1:0] value;
   } sli_cmd_type;

   // What one cell shows its neighbors. The open flag is set when the cell
   // is empty or holds a value greater than or equal to the one inserted.
   typedef struct packed {
      logic                          occ;
      logic                          open;
      logic signed [VALUE_WIDTH-1:0] value;
   } sli_link_type;

endpackage

>>> rtl/sli_cell.sv
// ----------------------------------------------------------------------------
// Sorted list cell
// Holds one entry. On insert it keeps its entry, takes the new value or takes
// its left neighbor's entry; on drain it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module sli_cell
   import sli_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  sli_cmd_type  cmd,
   input  sli_link_type left_link,
   input  sli_link_type right_link,
   output sli_link_type link,
   output logic         ins_point
);

   logic                          occ_ff, occ_in;
   logic signed [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                          ge;
   logic                          shift_in;

   assign ge        = occ_ff && (value_ff >= cmd.value);
   assign link.occ   = occ_ff;
   assign link.open  = ge || !occ_ff;
   assign link.value = value_ff;

   // The sorted order makes the open flags monotone along the row, so the
   // insertion point is the first open cell.
   assign ins_point = link.open && !left_link.open;
   assign shift_in  = left_link.occ && left_link.open;

   always_comb begin
      occ_in   = occ_ff;
      value_in = value_ff;
      if (cmd.drain) begin
         occ_in   = right_link.occ;
         value_in = right_link.value;
      end else if (cmd.insert) begin
         if (shift_in) begin
            occ_in   = 1'b1;
            value_in = left_link.value;
         end else if (ins_point) begin
            occ_in   = 1'b1;
            value_in = cmd.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
      value_ff <= value_in;
   end

endmodule

>>> rtl/sorted_list_insert_top.sv
// ----------------------------------------------------------------------------
// Sorted list insert
// Ascending list held in a row of cells. Inserts go before the first entry
// that is greater than or equal to the value; a drain streams the list out.
//
//   channel   ports                       handshake
//   request   req_item                    start, taken when busy is low
//   response  rsp_item                    rsp_valid, one cycle, no backpressure
//
// An insert's response appears the next cycle; a new request is taken every
// cycle while busy is low. A drain keeps busy high while the entries stream
// out, one entry per cycle shifted out of the head cell; an empty drain
// answers drained-empty without raising busy. Reset empties the list.
// ----------------------------------------------------------------------------
module sorted_list_insert_top
   import sli_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  sli_req_type req_item,
   output logic        rsp_valid,
   output sli_rsp_type rsp_item
);

   sli_cmd_type            cmd;
   sli_link_type           links [DEPTH];
   logic [DEPTH-1:0]       ins_pts;
   logic                   accept;
   logic                   full;
   logic [IDX_WIDTH-1:0]   ins_pos;

   logic                   drain_ff, drain_in;
   logic [IDX_WIDTH-1:0]   pos_ff, pos_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   sli_rsp_type            rsp_ff, rsp_in;

   assign busy      = drain_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign accept    = start && !drain_ff;
   assign full      = (count_ff == CNT_WIDTH'(DEPTH));

   assign cmd.insert = accept && (req_item.kind == KIND_INSERT) && !full;
   assign cmd.drain  = drain_ff;
   assign cmd.value  = VALUE_WIDTH'(req_item.value);

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      sli_link_type left_l, right_l;
      if (i == 0) begin : g_head
         assign left_l = '0;
      end else begin : g_mid
         assign left_l = links[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_l = '0;
      end else begin : g_body
         assign right_l = links[i+1];
      end
      sli_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_link  (left_l),
         .right_link (right_l),
         .link       (links[i]),
         .ins_point  (ins_pts[i])
      );
   end

   // The insertion point is one-hot whenever the list is not full.
   always_comb begin
      ins_pos = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (ins_pts[i]) begin
            ins_pos = ins_pos | IDX_WIDTH'(i);
         end
      end
   end

   always_comb begin
      drain_in     = drain_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      if (drain_ff) begin
         rsp_valid_in        = 1'b1;
         rsp_in.result_value = DATA_WIDTH'(links[0].value);
         rsp_in.position     = POS_WIDTH'(pos_ff);
         rsp_in.entry_count  = '0;
         rsp_in.status       = STATUS_DRAINED;
         rsp_in.last         = !links[1].occ;
         pos_in              = pos_ff + IDX_WIDTH'(1);
         if (!links[1].occ) begin
            drain_in = 1'b0;
         end
      end else if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_in.last  = 1'b1;
         if (req_item.kind == KIND_INSERT) begin
            rsp_in.result_value = req_item.value;
            if (full) begin
               rsp_in.position    = '0;
               rsp_in.entry_count = COUNT_WIDTH'(DEPTH);
               rsp_in.status      = STATUS_DROPPED;
            end else begin
               count_in           = count_ff + CNT_WIDTH'(1);
               rsp_in.position    = POS_WIDTH'(ins_pos);
               rsp_in.entry_count = COUNT_WIDTH'(count_in);
               rsp_in.status      = STATUS_INSERTED;
            end
         end else if (count_ff == '0) begin
            rsp_in.status = STATUS_DRAINED_EMPTY;
         end else begin
            // The cells stream the entries out over the following cycles.
            rsp_valid_in = 1'b0;
            drain_in     = 1'b1;
            pos_in       = '0;
            count_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         drain_ff     <= drain_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff <= pos_in;
      rsp_ff <= rsp_in;
   end

endmodule

>>> rtl/sli_checker.sv
// ----------------------------------------------------------------------------
// Sorted list insert checker
// Port-level checks on request and response timing and response positions.
// ----------------------------------------------------------------------------
module sli_checker
   import sli_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input sli_req_type req_item,
   input logic        rsp_valid,
   input sli_rsp_type rsp_item
);

   // An insert always answers in the next cycle with a single response.
   a_insert_rsp : assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.kind == KIND_INSERT |=>
         rsp_valid && rsp_item.last &&
         (rsp_item.status == STATUS_INSERTED || rsp_item.status == STATUS_DROPPED))
      else $error("insert request not answered in the next cycle");

   // A drain either answers empty next cycle or holds busy while streaming.
   a_drain_start : assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.kind == KIND_DRAIN |=>
         (rsp_valid && rsp_item.status == STATUS_DRAINED_EMPTY) || busy)
      else $error("drain request neither answered nor started");

   // Drained entries come in consecutive positions without gaps.
   a_drain_stream : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.last |=>
         rsp_valid && rsp_item.status == STATUS_DRAINED &&
         rsp_item.position == $past(rsp_item.position) + POS_WIDTH'(1))
      else $error("drain stream broken");

   // An inserted entry lies inside the list it joined.
   a_insert_pos : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status == STATUS_INSERTED |->
         COUNT_WIDTH'(rsp_item.position) < rsp_item.entry_count)
      else $error("insert position outside the list");

endmodule

bind sorted_list_insert_top sli_checker u_sli_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
